// File: src/ufs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package ufs_pkg;

  // field tags
  localparam logic [2:0] TAG_SCHEME = 3'd0;
  localparam logic [2:0] TAG_HOST   = 3'd1;
  localparam logic [2:0] TAG_PORT   = 3'd2;
  localparam logic [2:0] TAG_PATH   = 3'd3;
  localparam logic [2:0] TAG_QUERY  = 3'd4;
  localparam logic [2:0] TAG_DELIM  = 3'd5;
  localparam logic [2:0] TAG_IGN    = 3'd6;

  // parser phases
  localparam logic [3:0] PH_SCHEME     = 4'd0;
  localparam logic [3:0] PH_SLASH1     = 4'd1;
  localparam logic [3:0] PH_SLASH2     = 4'd2;
  localparam logic [3:0] PH_HOST_START = 4'd3;
  localparam logic [3:0] PH_HOST       = 4'd4;
  localparam logic [3:0] PH_HOST_BR    = 4'd5;
  localparam logic [3:0] PH_AFTER_HOST = 4'd6;
  localparam logic [3:0] PH_PORT       = 4'd7;
  localparam logic [3:0] PH_PATH       = 4'd8;
  localparam logic [3:0] PH_QUERY      = 4'd9;
  localparam logic [3:0] PH_IGNORE     = 4'd10;
  localparam logic [3:0] PH_ERROR      = 4'd11;

  // error codes
  localparam logic [2:0] ERR_NONE        = 3'd0;
  localparam logic [2:0] ERR_NO_COLON    = 3'd1;
  localparam logic [2:0] ERR_SCHEME_CHAR = 3'd2;
  localparam logic [2:0] ERR_SLASHES     = 3'd3;
  localparam logic [2:0] ERR_EMPTY_HOST  = 3'd4;
  localparam logic [2:0] ERR_AFTER_HOST  = 3'd5;

  // characters
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_QMARK  = 8'h3F;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_UP_A   = 8'h41;
  localparam logic [7:0] CH_UP_Z   = 8'h5A;
  localparam logic [7:0] CH_LO_A   = 8'h61;
  localparam logic [7:0] CH_LO_Z   = 8'h7A;
  localparam logic [7:0] CASE_OFS  = 8'h20;

  typedef struct packed {
    logic [3:0] phase;
    logic [2:0] err;
    logic       port_seen;
  } parse_state_t;

  typedef struct packed {
    logic [7:0] char_out;
    logic [2:0] field_tag;
    logic [2:0] error_code;
    logic       done_res;
    logic       port_defaulted;
  } parse_res_t;

endpackage
`default_nettype wire

// File: src/ufs_step.sv
`timescale 1ns / 1ps
`default_nettype none
module ufs_step (
  input  wire ufs_pkg::parse_state_t cur,
  input  wire logic [7:0]            ch,
  input  wire logic                  eos,
  output ufs_pkg::parse_state_t      nxt,
  output ufs_pkg::parse_res_t        res
);

  logic       is_upper;
  logic       is_lower;
  logic       scheme_ok;
  logic [2:0] end_err;

  assign is_upper  = (ch >= ufs_pkg::CH_UP_A) && (ch <= ufs_pkg::CH_UP_Z);
  assign is_lower  = (ch >= ufs_pkg::CH_LO_A) && (ch <= ufs_pkg::CH_LO_Z);
  assign scheme_ok = is_upper || is_lower || (ch == ufs_pkg::CH_PLUS) ||
                     (ch == ufs_pkg::CH_MINUS) || (ch == ufs_pkg::CH_DOT);

  always_comb begin
    end_err = cur.err;
    if (cur.phase == ufs_pkg::PH_SCHEME) begin
      end_err = ufs_pkg::ERR_NO_COLON;
    end else if (cur.err == ufs_pkg::ERR_NONE) begin
      if (cur.phase == ufs_pkg::PH_SLASH1 || cur.phase == ufs_pkg::PH_SLASH2) begin
        end_err = ufs_pkg::ERR_SLASHES;
      end else if (cur.phase == ufs_pkg::PH_HOST_START) begin
        end_err = ufs_pkg::ERR_EMPTY_HOST;
      end
    end
  end

  always_comb begin
    logic [2:0] tag;
    logic [7:0] co;
    logic [2:0] fail_code;
    logic       do_fail;
    nxt       = cur;
    tag       = ufs_pkg::TAG_IGN;
    co        = ch;
    fail_code = ufs_pkg::ERR_NONE;
    do_fail   = 1'b0;

    case (cur.phase)
      ufs_pkg::PH_SCHEME: begin
        if (ch == ufs_pkg::CH_COLON) begin
          tag       = ufs_pkg::TAG_DELIM;
          nxt.phase = (cur.err != ufs_pkg::ERR_NONE) ? ufs_pkg::PH_ERROR
                                                      : ufs_pkg::PH_SLASH1;
        end else begin
          tag = ufs_pkg::TAG_SCHEME;
          if (is_upper) co = ch + ufs_pkg::CASE_OFS;
          if (!scheme_ok && cur.err == ufs_pkg::ERR_NONE)
            nxt.err = ufs_pkg::ERR_SCHEME_CHAR;
        end
      end
      ufs_pkg::PH_SLASH1, ufs_pkg::PH_SLASH2: begin
        if (ch == ufs_pkg::CH_SLASH) begin
          tag       = ufs_pkg::TAG_DELIM;
          nxt.phase = (cur.phase == ufs_pkg::PH_SLASH1) ? ufs_pkg::PH_SLASH2
                                                         : ufs_pkg::PH_HOST_START;
        end else begin
          do_fail   = 1'b1;
          fail_code = ufs_pkg::ERR_SLASHES;
        end
      end
      ufs_pkg::PH_HOST_START: begin
        if (ch == ufs_pkg::CH_LBRACK) begin
          tag       = ufs_pkg::TAG_HOST;
          nxt.phase = ufs_pkg::PH_HOST_BR;
        end else if (ch == ufs_pkg::CH_COLON || ch == ufs_pkg::CH_SLASH) begin
          do_fail   = 1'b1;
          fail_code = ufs_pkg::ERR_EMPTY_HOST;
        end else begin
          tag       = ufs_pkg::TAG_HOST;
          nxt.phase = ufs_pkg::PH_HOST;
        end
      end
      ufs_pkg::PH_HOST, ufs_pkg::PH_AFTER_HOST: begin
        if (ch == ufs_pkg::CH_COLON) begin
          tag           = ufs_pkg::TAG_DELIM;
          nxt.port_seen = 1'b1;
          nxt.phase     = ufs_pkg::PH_PORT;
        end else if (ch == ufs_pkg::CH_SLASH) begin
          tag       = ufs_pkg::TAG_DELIM;
          nxt.phase = ufs_pkg::PH_PATH;
        end else if (cur.phase == ufs_pkg::PH_HOST) begin
          tag = ufs_pkg::TAG_HOST;
        end else begin
          do_fail   = 1'b1;
          fail_code = ufs_pkg::ERR_AFTER_HOST;
        end
      end
      ufs_pkg::PH_HOST_BR: begin
        tag = ufs_pkg::TAG_HOST;
        if (ch == ufs_pkg::CH_RBRACK) nxt.phase = ufs_pkg::PH_AFTER_HOST;
      end
      ufs_pkg::PH_PORT: begin
        if (ch == ufs_pkg::CH_SLASH) begin
          tag       = ufs_pkg::TAG_DELIM;
          nxt.phase = ufs_pkg::PH_PATH;
        end else begin
          tag = ufs_pkg::TAG_PORT;
        end
      end
      ufs_pkg::PH_PATH: begin
        if (ch == ufs_pkg::CH_QMARK) begin
          tag       = ufs_pkg::TAG_DELIM;
          nxt.phase = ufs_pkg::PH_QUERY;
        end else if (ch == ufs_pkg::CH_HASH) begin
          tag       = ufs_pkg::TAG_DELIM;
          nxt.phase = ufs_pkg::PH_IGNORE;
        end else begin
          tag = ufs_pkg::TAG_PATH;
        end
      end
      ufs_pkg::PH_QUERY: begin
        if (ch == ufs_pkg::CH_HASH) begin
          tag       = ufs_pkg::TAG_DELIM;
          nxt.phase = ufs_pkg::PH_IGNORE;
        end else begin
          tag = ufs_pkg::TAG_QUERY;
        end
      end
      default: begin
        tag = ufs_pkg::TAG_IGN;
      end
    endcase

    // first error wins; the failing byte is already tagged ignored
    if (do_fail) begin
      if (cur.err == ufs_pkg::ERR_NONE) nxt.err = fail_code;
      nxt.phase = ufs_pkg::PH_ERROR;
    end

    res.char_out       = co;
    res.field_tag      = tag;
    res.error_code     = nxt.err;
    res.done_res       = 1'b0;
    res.port_defaulted = 1'b0;

    // terminator: report and restart
    if (eos) begin
      nxt.phase          = ufs_pkg::PH_SCHEME;
      nxt.err            = ufs_pkg::ERR_NONE;
      nxt.port_seen      = 1'b0;
      res.char_out       = 8'h00;
      res.field_tag      = ufs_pkg::TAG_IGN;
      res.error_code     = end_err;
      res.done_res       = 1'b1;
      res.port_defaulted = (end_err == ufs_pkg::ERR_NONE) && !cur.port_seen;
    end
  end

endmodule
`default_nettype wire

// File: src/url_field_splitter.sv
`timescale 1ns / 1ps
`default_nettype none
// Path: input register, one parse step, output register driving out_*.
// Throughput: one byte per cycle while the output register is not stalled.
// in_stall rises only when both registers hold data and out_stall is high.
// Reset (rst_n low, synchronous) empties both registers and returns the parser
// to the scheme phase with no error latched and no port seen.
module url_field_splitter (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] in_char_in,
  input  wire logic       in_end_of_string,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [7:0]      out_char_out,
  output logic [2:0]      out_field_tag,
  output logic [2:0]      out_error_code,
  output logic            out_done_res,
  output logic            out_port_defaulted
);

  logic                  s1_valid_r;
  logic [7:0]            s1_char_r;
  logic                  s1_eos_r;
  logic                  out_valid_r;
  ufs_pkg::parse_res_t   res_r;
  ufs_pkg::parse_state_t state_r;
  ufs_pkg::parse_state_t state_nxt;
  ufs_pkg::parse_res_t   res_nxt;
  logic                  advance;
  logic                  in_acc;

  assign advance  = !out_valid_r || !out_stall;
  assign in_stall = s1_valid_r && !advance;
  assign in_acc   = in_valid && !in_stall;

  ufs_step u_step (
    .cur (state_r),
    .ch  (s1_char_r),
    .eos (s1_eos_r),
    .nxt (state_nxt),
    .res (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      state_r     <= '{phase: ufs_pkg::PH_SCHEME, err: ufs_pkg::ERR_NONE, port_seen: 1'b0};
    end else begin
      if (in_acc) begin
        s1_valid_r <= 1'b1;
      end else if (advance) begin
        s1_valid_r <= 1'b0;
      end
      if (advance) begin
        out_valid_r <= s1_valid_r;
        if (s1_valid_r) state_r <= state_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_char_r <= in_char_in;
      s1_eos_r  <= in_end_of_string;
    end
    if (advance && s1_valid_r) res_r <= res_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_char_out       = res_r.char_out;
  assign out_field_tag      = res_r.field_tag;
  assign out_error_code     = res_r.error_code;
  assign out_done_res       = res_r.done_res;
  assign out_port_defaulted = res_r.port_defaulted;

`ifndef SYNTHESIS
  a_end_resets: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && s1_valid_r && s1_eos_r) |=>
      (state_r.phase == ufs_pkg::PH_SCHEME && state_r.err == ufs_pkg::ERR_NONE &&
       !state_r.port_seen))
    else $error("parser state not cleared after end of string");

  a_error_latched: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r.phase == ufs_pkg::PH_ERROR) |-> (state_r.err != ufs_pkg::ERR_NONE))
    else $error("error phase without latched error");

  a_done_shape: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_done_res) |->
      (out_char_out == 8'h00 && out_field_tag == ufs_pkg::TAG_IGN))
    else $error("end result carries a byte");

  a_port_default: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_port_defaulted) |->
      (out_done_res && out_error_code == ufs_pkg::ERR_NONE))
    else $error("port default outside a clean end result");
`endif

endmodule
`default_nettype wire

// File: verif/tb_url_field_splitter.sv
`timescale 1ns / 1ps
module tb_url_field_splitter;

  localparam int IDLE_LIMIT   = 1000;
  localparam int RANDOM_ITEMS = 450;
  localparam int MAX_PRINTS   = 30;

  // Tracks the parser state and holds the tagged bytes still owed by the block.
  class url_tag_scoreboard;
    logic [3:0]          phase;
    logic [2:0]          err;
    logic                port_seen;
    ufs_pkg::parse_res_t expected_tags[$];
    int                  fail_count;
    int                  result_idx;

    function new();
      phase      = ufs_pkg::PH_SCHEME;
      err        = ufs_pkg::ERR_NONE;
      port_seen  = 1'b0;
      fail_count = 0;
      result_idx = 0;
    endfunction

    function void report(input string msg);
      fail_count++;
      if (fail_count <= MAX_PRINTS) begin
        $display("[%0t] mismatch on result %0d: %s", $time, result_idx, msg);
      end
    endfunction

    function bit scheme_legal(input logic [7:0] c);
      return (c >= ufs_pkg::CH_UP_A && c <= ufs_pkg::CH_UP_Z) ||
             (c >= ufs_pkg::CH_LO_A && c <= ufs_pkg::CH_LO_Z) ||
             c == ufs_pkg::CH_PLUS || c == ufs_pkg::CH_MINUS || c == ufs_pkg::CH_DOT;
    endfunction

    // first error wins; the rest of the URL is ignored
    function logic [2:0] give_up(input logic [2:0] code);
      if (err == ufs_pkg::ERR_NONE) begin
        err = code;
      end
      phase = ufs_pkg::PH_ERROR;
      return ufs_pkg::TAG_IGN;
    endfunction

    function void note_request(input logic [7:0] c, input logic eos);
      ufs_pkg::parse_res_t r;
      logic [2:0]          code;
      r.char_out       = c;
      r.field_tag      = ufs_pkg::TAG_IGN;
      r.error_code     = ufs_pkg::ERR_NONE;
      r.done_res       = 1'b0;
      r.port_defaulted = 1'b0;
      if (eos) begin
        case (phase)
          ufs_pkg::PH_SCHEME: begin
            code = ufs_pkg::ERR_NO_COLON;
          end
          ufs_pkg::PH_SLASH1, ufs_pkg::PH_SLASH2: begin
            code = (err != ufs_pkg::ERR_NONE) ? err : ufs_pkg::ERR_SLASHES;
          end
          ufs_pkg::PH_HOST_START: begin
            code = (err != ufs_pkg::ERR_NONE) ? err : ufs_pkg::ERR_EMPTY_HOST;
          end
          default: begin
            code = err;
          end
        endcase
        r.char_out       = 8'h00;
        r.error_code     = code;
        r.done_res       = 1'b1;
        r.port_defaulted = (code == ufs_pkg::ERR_NONE) && !port_seen;
        phase     = ufs_pkg::PH_SCHEME;
        err       = ufs_pkg::ERR_NONE;
        port_seen = 1'b0;
      end else begin
        case (phase)
          ufs_pkg::PH_SCHEME: begin
            if (c == ufs_pkg::CH_COLON) begin
              r.field_tag = ufs_pkg::TAG_DELIM;
              phase = (err != ufs_pkg::ERR_NONE) ? ufs_pkg::PH_ERROR : ufs_pkg::PH_SLASH1;
            end else begin
              r.field_tag = ufs_pkg::TAG_SCHEME;
              if (c >= ufs_pkg::CH_UP_A && c <= ufs_pkg::CH_UP_Z) begin
                r.char_out = c + ufs_pkg::CASE_OFS;
              end
              if (!scheme_legal(c) && err == ufs_pkg::ERR_NONE) begin
                err = ufs_pkg::ERR_SCHEME_CHAR;
              end
            end
          end
          ufs_pkg::PH_SLASH1, ufs_pkg::PH_SLASH2: begin
            if (c == ufs_pkg::CH_SLASH) begin
              r.field_tag = ufs_pkg::TAG_DELIM;
              phase = (phase == ufs_pkg::PH_SLASH1) ? ufs_pkg::PH_SLASH2
                                                    : ufs_pkg::PH_HOST_START;
            end else begin
              r.field_tag = give_up(ufs_pkg::ERR_SLASHES);
            end
          end
          ufs_pkg::PH_HOST_START: begin
            if (c == ufs_pkg::CH_LBRACK) begin
              r.field_tag = ufs_pkg::TAG_HOST;
              phase = ufs_pkg::PH_HOST_BR;
            end else if (c == ufs_pkg::CH_COLON || c == ufs_pkg::CH_SLASH) begin
              r.field_tag = give_up(ufs_pkg::ERR_EMPTY_HOST);
            end else begin
              r.field_tag = ufs_pkg::TAG_HOST;
              phase = ufs_pkg::PH_HOST;
            end
          end
          ufs_pkg::PH_HOST, ufs_pkg::PH_AFTER_HOST: begin
            if (c == ufs_pkg::CH_COLON) begin
              r.field_tag = ufs_pkg::TAG_DELIM;
              port_seen = 1'b1;
              phase = ufs_pkg::PH_PORT;
            end else if (c == ufs_pkg::CH_SLASH) begin
              r.field_tag = ufs_pkg::TAG_DELIM;
              phase = ufs_pkg::PH_PATH;
            end else if (phase == ufs_pkg::PH_HOST) begin
              r.field_tag = ufs_pkg::TAG_HOST;
            end else begin
              r.field_tag = give_up(ufs_pkg::ERR_AFTER_HOST);
            end
          end
          ufs_pkg::PH_HOST_BR: begin
            r.field_tag = ufs_pkg::TAG_HOST;
            if (c == ufs_pkg::CH_RBRACK) begin
              phase = ufs_pkg::PH_AFTER_HOST;
            end
          end
          ufs_pkg::PH_PORT: begin
            if (c == ufs_pkg::CH_SLASH) begin
              r.field_tag = ufs_pkg::TAG_DELIM;
              phase = ufs_pkg::PH_PATH;
            end else begin
              r.field_tag = ufs_pkg::TAG_PORT;
            end
          end
          ufs_pkg::PH_PATH: begin
            if (c == ufs_pkg::CH_QMARK) begin
              r.field_tag = ufs_pkg::TAG_DELIM;
              phase = ufs_pkg::PH_QUERY;
            end else if (c == ufs_pkg::CH_HASH) begin
              r.field_tag = ufs_pkg::TAG_DELIM;
              phase = ufs_pkg::PH_IGNORE;
            end else begin
              r.field_tag = ufs_pkg::TAG_PATH;
            end
          end
          ufs_pkg::PH_QUERY: begin
            if (c == ufs_pkg::CH_HASH) begin
              r.field_tag = ufs_pkg::TAG_DELIM;
              phase = ufs_pkg::PH_IGNORE;
            end else begin
              r.field_tag = ufs_pkg::TAG_QUERY;
            end
          end
          default: begin
            r.field_tag = ufs_pkg::TAG_IGN;
          end
        endcase
        r.error_code = err;
      end
      expected_tags.push_back(r);
    endfunction

    function void compare_field(input string name, input logic [7:0] got,
                                input logic [7:0] want);
      if (got !== want) begin
        report($sformatf("%s got %h expected %h", name, got, want));
      end
    endfunction

    function void check_result(input ufs_pkg::parse_res_t got);
      ufs_pkg::parse_res_t want;
      if (expected_tags.size() == 0) begin
        report($sformatf("unexpected result char %h tag %0d", got.char_out, got.field_tag));
      end else begin
        want = expected_tags.pop_front();
        compare_field("char_out", got.char_out, want.char_out);
        compare_field("field_tag", 8'(got.field_tag), 8'(want.field_tag));
        compare_field("error_code", 8'(got.error_code), 8'(want.error_code));
        compare_field("done_res", 8'(got.done_res), 8'(want.done_res));
        compare_field("port_defaulted", 8'(got.port_defaulted),
                      8'(want.port_defaulted));
      end
      result_idx++;
    endfunction
  endclass

  logic       clk              = 1'b0;
  logic       rst_n            = 1'b0;
  logic       in_valid         = 1'b0;
  logic [7:0] in_char_in       = 8'h00;
  logic       in_end_of_string = 1'b0;
  logic       out_stall        = 1'b0;
  logic       in_stall;
  logic       out_valid;
  logic [7:0] out_char_out;
  logic [2:0] out_field_tag;
  logic [2:0] out_error_code;
  logic       out_done_res;
  logic       out_port_defaulted;

  url_tag_scoreboard tag_board;
  logic [7:0]        url_q[$];
  int                burst_left  = 0;
  int                sent_cnt    = 0;
  int                idle_cycles = 0;
  int                stall_hold  = 0;

  url_field_splitter i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_char_in        (in_char_in),
    .in_end_of_string  (in_end_of_string),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_char_out      (out_char_out),
    .out_field_tag     (out_field_tag),
    .out_error_code    (out_error_code),
    .out_done_res      (out_done_res),
    .out_port_defaulted(out_port_defaulted)
  );

  always #5 clk = ~clk;

  // receiver: quiet stretches mixed with short toggling stall runs
  always @(negedge clk) begin
    if (stall_hold == 0) begin
      if ($urandom_range(0, 3) == 0) begin
        out_stall  = 1'b0;
        stall_hold = $urandom_range(20, 60);
      end else begin
        out_stall  = ~out_stall;
        stall_hold = $urandom_range(1, 6);
      end
    end
    stall_hold--;
  end

  always @(posedge clk) begin : result_monitor
    ufs_pkg::parse_res_t got;
    if (rst_n === 1'b1) begin
      if (out_valid === 1'b1 && out_stall === 1'b0) begin
        got.char_out       = out_char_out;
        got.field_tag      = out_field_tag;
        got.error_code     = out_error_code;
        got.done_res       = out_done_res;
        got.port_defaulted = out_port_defaulted;
        tag_board.check_result(got);
      end
      if ((out_valid === 1'b1 && out_stall === 1'b0) ||
          (in_valid === 1'b1 && in_stall === 1'b0)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
  end

  initial begin : watchdog
    while (idle_cycles < IDLE_LIMIT) @(posedge clk);
    $display("url_field_splitter regression: fail");
    $finish;
  end

  // called and returns at a falling edge; valid stays high inside a burst
  task automatic send_req(input logic [7:0] c, input logic eos);
    int gap;
    in_valid         = 1'b1;
    in_char_in       = c;
    in_end_of_string = eos;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    tag_board.note_request(c, eos);
    sent_cnt++;
    @(negedge clk);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 15);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        in_valid         = 1'b0;
        in_char_in       = 8'($urandom_range(0, 255));
        in_end_of_string = 1'($urandom_range(0, 1));
        repeat (gap) @(negedge clk);
      end
    end
  endtask

  task automatic send_url();
    foreach (url_q[i]) send_req(url_q[i], 1'b0);
    send_req(8'($urandom_range(0, 255)), 1'b1);
    url_q.delete();
  endtask

  function automatic void append_text(input string s);
    for (int i = 0; i < s.len(); i++) url_q.push_back(s[i]);
  endfunction

  function automatic void append_pick(input string s, input int cnt);
    repeat (cnt) url_q.push_back(s[$urandom_range(0, s.len() - 1)]);
  endfunction

  function automatic void append_noise(input int cnt);
    repeat (cnt) url_q.push_back(8'($urandom_range(0, 255)));
  endfunction

  // mostly well-formed URLs with random content; some noise, errors and cut-offs
  function automatic void build_random_url();
    int keep;
    if ($urandom_range(0, 9) == 0) begin
      append_noise($urandom_range(0, 8));
      return;
    end
    append_pick("abcmxyzABCMXYZ+-.", $urandom_range(0, 5));
    if ($urandom_range(0, 11) == 0) begin
      append_noise(1);
    end
    if ($urandom_range(0, 7) != 0) begin
      append_text(":");
    end
    if ($urandom_range(0, 9) != 0) begin
      append_text("//");
    end else begin
      append_pick("/x:", 1);
    end
    if ($urandom_range(0, 4) == 0) begin
      append_text("[");
      append_pick("0123456789abcdef:.", $urandom_range(0, 4));
      if ($urandom_range(0, 5) != 0) begin
        append_text("]");
      end
      if ($urandom_range(0, 5) == 0) begin
        append_pick("x@]a", 1);
      end
    end else begin
      append_pick("abcxyz0189.-_ABZ", $urandom_range(0, 6));
    end
    if ($urandom_range(0, 2) == 0) begin
      append_text(":");
      append_pick("0123456789", $urandom_range(0, 4));
    end
    if ($urandom_range(0, 9) < 7) begin
      append_text("/");
      append_pick("abz09/._~%-?#", $urandom_range(0, 6));
    end
    if ($urandom_range(0, 2) == 0) begin
      append_text("?");
      append_pick("a=&z09?/%", $urandom_range(0, 5));
    end
    if ($urandom_range(0, 3) == 0) begin
      append_text("#");
      append_noise($urandom_range(0, 4));
    end
    if ($urandom_range(0, 9) == 0 && url_q.size() > 0) begin
      keep = $urandom_range(0, url_q.size() - 1);
      while (url_q.size() > keep) void'(url_q.pop_back());
    end
  endfunction

  initial begin : stimulus
    int random_start;
    tag_board = new();
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // end right away: no colon
    send_url();
    // still in the scheme at the end, upper case folded
    append_text("Z");
    send_url();
    // second slash never comes
    append_text("-.:/");
    send_url();
    // zero byte is an illegal scheme char, kept latched past the colon
    url_q.push_back(8'h00);
    append_text(":");
    send_url();
    // nothing after the slashes
    append_text("a://");
    send_url();
    // slash missing
    append_text("a:x");
    send_url();
    // bracket never closed is fine, port defaults
    append_text("b://[");
    send_url();

    random_start = sent_cnt;
    while (sent_cnt - random_start < RANDOM_ITEMS) begin
      build_random_url();
      send_url();
    end
    in_valid = 1'b0;

    while (tag_board.expected_tags.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (tag_board.fail_count == 0) begin
      $display("url_field_splitter regression: pass");
    end else begin
      $display("url_field_splitter regression: fail");
    end
    $finish;
  end

endmodule

// File: sim.f
src/ufs_pkg.sv
src/ufs_step.sv
src/url_field_splitter.sv
verif/tb_url_field_splitter.sv
